[hdl/swic_pkg.sv]
// ----------------------------------------------------------------------------
// swic_pkg
// Shared types and fixed field widths for the sliding window inversion counter.
// ----------------------------------------------------------------------------
package swic_pkg;

   localparam int SAMPLE_W     = 10;
   localparam int WINDOW_LEN_W = 11;
   localparam int INV_W        = 19;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 40;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // register index (byte address / 4)
   localparam logic [0:0] CSR_IDX_WINDOW_LEN = 1'b0;

   typedef enum logic [1:0] {
      TREE_QUERY,
      TREE_ADD,
      TREE_SUB,
      TREE_CLEAR
   } tree_op_type;

   typedef struct packed {
      logic        start;
      tree_op_type op;
   } tree_cmd_type;

   typedef enum logic [1:0] {
      WK_IDLE,
      WK_QUERY,
      WK_UPDATE,
      WK_CLEAR
   } walk_state_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_INIT_WIPE,
      ST_IDLE,
      ST_ITEM_WIPE,
      ST_CHECK,
      ST_OLD_QUERY,
      ST_OLD_QWAIT,
      ST_OLD_UWAIT,
      ST_NEW_QWAIT,
      ST_NEW_UWAIT,
      ST_BEST,
      ST_EMIT
   } seq_state_type;

endpackage

[hdl/sliding_window_inversion_count.sv]
// ----------------------------------------------------------------------------
// sliding_window_inversion_count
// Inversion count over a sliding window of unsigned samples, with the running
// minimum over full windows.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Each sample takes a prefix query and a
// +1 update of the count tree, plus a query and a -1 update for every sample
// leaving the window (normally one once the window is full). A query walks
// the set bits of its start node and an update climbs the tree levels, both
// on the tree walker, which has one memory read port and one adder. After
// reset the tree is swept clear with req_tready low; a transaction flagged
// first sweeps it again unless nothing has been added since the last sweep.
// window_len 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW;
// min_inversions reads all ones until the first full window.
// ----------------------------------------------------------------------------
module sliding_window_inversion_count import swic_pkg::*; #(
   parameter int VALUE_COUNT = 1024,
   parameter int MAX_WINDOW  = 1024
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] sample_value, rest zero
   input  logic                   req_tuser,   // [0] first

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [18:0] current_inversions,
                                                // [37:19] min_inversions,
                                                // [38] window_full, [39] zero

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int AW     = $clog2(VALUE_COUNT);
   localparam int UW     = AW + 2;
   localparam int FW     = $clog2(MAX_WINDOW + 1);
   localparam int PW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SW     = FW + 1;
   localparam int RW_MIN = 2 * FW;
   localparam int RW     = (RW_MIN > INV_W) ? RW_MIN : INV_W;

   // configuration
   logic [WINDOW_LEN_W-1:0] window_len_ff, window_len_in;
   logic                    csr_write;
   logic [0:0]              csr_idx;

   // sequencer state
   seq_state_type state_ff, state_in;
   logic [AW-1:0] val_ff, val_in;
   logic [AW-1:0] old_ff, old_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [RW-1:0] running_ff, running_in;
   logic [RW-1:0] best_ff, best_in;
   logic          best_valid_ff, best_valid_in;
   logic          dirty_ff, dirty_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [FW-1:0]   len_eff;
   logic [AW-1:0]   val_clamped;
   logic [SW-1:0]   pos_sum;
   logic [PW-1:0]   old_pos;
   logic            drop;
   logic            full;
   logic            accept;
   logic [INV_W-1:0] min_out;

   tree_cmd_type    tree_cmd;
   logic [UW-1:0]   tree_node;
   logic            tree_done;
   logic [FW-1:0]   tree_sum;

   logic            ring_we;
   logic [AW-1:0]   ring_rd_data;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      window_len_in = window_len_ff;
      if (csr_write && (csr_idx == CSR_IDX_WINDOW_LEN)) begin
         window_len_in = csr_pwdata[WINDOW_LEN_W-1:0];
      end
      if (csr_idx == CSR_IDX_WINDOW_LEN) begin
         csr_prdata = CSR_DATA_W'(window_len_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      if (window_len_ff == '0) begin
         len_eff = FW'(1);
      end else if (32'(window_len_ff) > MAX_WINDOW) begin
         len_eff = FW'(MAX_WINDOW);
      end else begin
         len_eff = FW'(window_len_ff);
      end

      if (32'(req_tdata[SAMPLE_W-1:0]) >= VALUE_COUNT) begin
         val_clamped = AW'(VALUE_COUNT - 1);
      end else begin
         val_clamped = AW'(req_tdata[SAMPLE_W-1:0]);
      end

      // oldest entry of the ring
      pos_sum = SW'(wp_ff) + SW'(MAX_WINDOW) - SW'(fill_ff);
      if (pos_sum >= SW'(MAX_WINDOW)) begin
         old_pos = PW'(pos_sum - SW'(MAX_WINDOW));
      end else begin
         old_pos = PW'(pos_sum);
      end

      drop    = (fill_ff >= len_eff) && (fill_ff != '0);
      full    = (fill_ff == len_eff);
      min_out = best_valid_ff ? best_ff[INV_W-1:0] : '1;
   end

   // ---------------------------------------------------------------- sequencer
   assign accept = req_tvalid & req_tready;

   always_comb begin
      state_in      = state_ff;
      val_in        = val_ff;
      old_in        = old_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      running_in    = running_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      dirty_in      = dirty_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      tree_cmd      = '{start: 1'b0, op: TREE_QUERY};
      tree_node     = UW'(val_ff) + UW'(1);
      ring_we       = 1'b0;
      req_tready    = 1'b0;

      case (state_ff)
         ST_INIT: begin
            tree_cmd = '{start: 1'b1, op: TREE_CLEAR};
            dirty_in = 1'b0;
            state_in = ST_INIT_WIPE;
         end
         ST_INIT_WIPE: begin
            if (tree_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               val_in = val_clamped;
               if (req_tuser) begin
                  wp_in         = '0;
                  fill_in       = '0;
                  running_in    = '0;
                  best_valid_in = 1'b0;
                  if (dirty_ff) begin
                     tree_cmd = '{start: 1'b1, op: TREE_CLEAR};
                     dirty_in = 1'b0;
                     state_in = ST_ITEM_WIPE;
                  end else begin
                     state_in = ST_CHECK;
                  end
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_ITEM_WIPE: begin
            if (tree_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // ring read of the oldest entry is presented this cycle
            if (drop) begin
               state_in = ST_OLD_QUERY;
            end else begin
               tree_cmd = '{start: 1'b1, op: TREE_QUERY};
               state_in = ST_NEW_QWAIT;
            end
         end
         ST_OLD_QUERY: begin
            old_in    = ring_rd_data;
            tree_node = UW'(ring_rd_data);
            tree_cmd  = '{start: 1'b1, op: TREE_QUERY};
            state_in  = ST_OLD_QWAIT;
         end
         ST_OLD_QWAIT: begin
            if (tree_done) begin
               running_in = running_ff - RW'(tree_sum);
               tree_node  = UW'(old_ff) + UW'(1);
               tree_cmd   = '{start: 1'b1, op: TREE_SUB};
               state_in   = ST_OLD_UWAIT;
            end
         end
         ST_OLD_UWAIT: begin
            if (tree_done) begin
               fill_in  = fill_ff - FW'(1);
               state_in = ST_CHECK;
            end
         end
         ST_NEW_QWAIT: begin
            if (tree_done) begin
               // earlier elements strictly greater than the new value
               running_in = running_ff + RW'(fill_ff) - RW'(tree_sum);
               tree_cmd   = '{start: 1'b1, op: TREE_ADD};
               dirty_in   = 1'b1;
               state_in   = ST_NEW_UWAIT;
            end
         end
         ST_NEW_UWAIT: begin
            if (tree_done) begin
               ring_we  = 1'b1;
               wp_in    = (wp_ff == PW'(MAX_WINDOW - 1)) ? '0 : wp_ff + PW'(1);
               fill_in  = fill_ff + FW'(1);
               state_in = ST_BEST;
            end
         end
         ST_BEST: begin
            if (full && (!best_valid_ff || (running_ff < best_ff))) begin
               best_in       = running_ff;
               best_valid_in = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, full, min_out, running_ff[INV_W-1:0]};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         window_len_ff <= WINDOW_LEN_W'(1);
         wp_ff         <= '0;
         fill_ff       <= '0;
         running_ff    <= '0;
         best_valid_ff <= 1'b0;
         dirty_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         running_ff    <= running_in;
         best_valid_ff <= best_valid_in;
         dirty_ff      <= dirty_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      old_ff       <= old_in;
      best_ff      <= best_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------- units
   swic_tree #(
      .VALUE_COUNT (VALUE_COUNT),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_tree (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tree_cmd),
      .cmd_node (tree_node),
      .done     (tree_done),
      .sum      (tree_sum)
   );

   swic_ring #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (val_ff),
      .rd_addr (old_pos),
      .rd_data (ring_rd_data)
   );

endmodule

[hdl/swic_ring.sv]
// ----------------------------------------------------------------------------
// swic_ring
// Window value store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swic_ring #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [PW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/swic_tree.sv]
// ----------------------------------------------------------------------------
// swic_tree
// Fenwick tree of value counts with a single adder walking the tree levels:
// prefix query, +1/-1 update and a clearing sweep.
// ----------------------------------------------------------------------------
module swic_tree import swic_pkg::*; #(
   parameter int VALUE_COUNT = 1024,
   parameter int MAX_WINDOW  = 1024,
   localparam int AW = $clog2(VALUE_COUNT),
   localparam int UW = AW + 2,
   localparam int CW = $clog2(MAX_WINDOW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  tree_cmd_type  cmd,
   input  logic [UW-1:0] cmd_node,
   output logic          done,
   output logic [CW-1:0] sum
);

   logic [CW-1:0] mem [VALUE_COUNT];

   walk_state_type state_ff, state_in;
   tree_op_type    op_ff, op_in;
   logic [UW-1:0]  node_ff, node_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  wb_addr_ff, wb_addr_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [CW-1:0]  sum_ff, sum_in;
   logic [CW-1:0]  rdata_ff;

   logic [AW-1:0]  raddr;
   logic [AW-1:0]  waddr;
   logic           we;
   logic [CW-1:0]  wdata;
   logic [CW-1:0]  addend;
   logic [CW-1:0]  adder;
   logic [UW-1:0]  lowbit;
   logic [AW-1:0]  node_addr;

   always_comb begin
      // the one adder: accumulate in a query, +/-1 in an update
      case (op_ff)
         TREE_QUERY: addend = sum_ff;
         TREE_SUB:   addend = '1;
         default:    addend = CW'(1);
      endcase
      adder     = addend + rdata_ff;
      lowbit    = node_ff & (~node_ff + UW'(1));
      node_addr = AW'(node_ff - UW'(1));

      state_in   = state_ff;
      op_in      = op_ff;
      node_in    = node_ff;
      pend_in    = pend_ff;
      wb_addr_in = wb_addr_ff;
      clr_in     = clr_ff;
      sum_in     = sum_ff;
      raddr      = node_addr;
      we         = 1'b0;
      waddr      = wb_addr_ff;
      wdata      = adder;
      done       = 1'b0;

      case (state_ff)
         WK_QUERY: begin
            pend_in = 1'b0;
            if (pend_ff) begin
               sum_in = adder;
            end
            if (node_ff != '0) begin
               pend_in = 1'b1;
               node_in = node_ff & (node_ff - UW'(1));
            end else if (!pend_ff) begin
               done     = 1'b1;
               state_in = WK_IDLE;
            end
         end
         WK_UPDATE: begin
            pend_in = 1'b0;
            // write back the node read last cycle while reading the next one
            if (pend_ff) begin
               we = 1'b1;
            end
            if (node_ff <= UW'(VALUE_COUNT)) begin
               pend_in    = 1'b1;
               wb_addr_in = node_addr;
               node_in    = node_ff + lowbit;
            end else if (!pend_ff) begin
               done     = 1'b1;
               state_in = WK_IDLE;
            end
         end
         WK_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(VALUE_COUNT - 1)) begin
               done     = 1'b1;
               state_in = WK_IDLE;
            end
         end
         default: ;
      endcase

      if (((state_ff == WK_IDLE) || done) && cmd.start) begin
         op_in   = cmd.op;
         node_in = cmd_node;
         sum_in  = '0;
         pend_in = 1'b0;
         clr_in  = '0;
         case (cmd.op)
            TREE_QUERY: state_in = WK_QUERY;
            TREE_CLEAR: state_in = WK_CLEAR;
            default:    state_in = WK_UPDATE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WK_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      node_ff    <= node_in;
      wb_addr_ff <= wb_addr_in;
      clr_ff     <= clr_in;
      sum_ff     <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign sum = sum_ff;

endmodule
